// File: src/lcsr_pkg.sv
package lcsr_pkg;

    localparam int DATA_BITS = 24;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 16;
    localparam int TIMER_W   = 24;
    localparam int HALF_W    = 8;
    localparam int GAP_W     = 16;
    localparam int OFFSET_W  = 25;
    localparam int AVG_W     = 24;
    localparam int NET_W     = 26;
    localparam int CFG_W     = 25;
    localparam int IDX_W     = 3;
    localparam int PULSE_W   = $clog2(DATA_BITS + 2);
    localparam int STEP_W    = $clog2(SUM_W);

    localparam logic [IDX_W-1:0] REG_HALF_PERIOD  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAP          = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET       = 3'd4;

    localparam logic [HALF_W-1:0]   HALF_RESET    = 8'd1;
    localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 24'd150000;
    localparam logic [GAP_W-1:0]    GAP_RESET     = 16'd5000;
    localparam logic [CNT_W-1:0]    COUNT_RESET   = 16'd1;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET  = '0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0]   half_period_ticks;
        logic [TIMER_W-1:0]  timeout_ticks;
        logic [GAP_W-1:0]    gap_ticks;
        logic [CNT_W-1:0]    sample_count;
        logic [OFFSET_W-1:0] offset;
    } cfg_t;

    typedef struct packed {
        logic meas_clr;
        logic timer_clr;
        logic timer_inc;
        logic word_clr;
        logic shift_en;
        logic pulse_inc;
        logic finish_zero;
        logic finish_word;
        logic timeout_inc;
        logic clk_hi;
        logic clk_lo;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic timer_ge_timeout;
        logic half_hit;
        logic pulse_lt;
        logic timer_ge_gap;
        logic readings_ge_n;
    } status_t;

endpackage

// File: src/lcsr_div.sv
module lcsr_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lcsr_pkg::SUM_W-1:0] dividend,
    input  logic [lcsr_pkg::CNT_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [lcsr_pkg::SUM_W-1:0] quotient
);
    import lcsr_pkg::*;

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/lcsr_dpath.sv
module lcsr_dpath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lcsr_pkg::cfg_t             cfg,
    input  lcsr_pkg::cmd_t             cmd,
    input  logic                       din,
    output lcsr_pkg::status_t          status,
    output logic                       clock_level_next,
    output logic [lcsr_pkg::SUM_W-1:0] reading_sum,
    output logic [lcsr_pkg::CNT_W-1:0] readings_done,
    output logic [lcsr_pkg::CNT_W-1:0] timeouts_seen
);
    import lcsr_pkg::*;

    logic [TIMER_W-1:0]   tick_timer_reg, tick_timer_next;
    logic [PULSE_W-1:0]   pulse_index_reg, pulse_index_next;
    logic [DATA_BITS-1:0] shift_word_reg, shift_word_next;
    logic [SUM_W-1:0]     reading_sum_reg, reading_sum_next;
    logic [CNT_W-1:0]     readings_done_reg, readings_done_next;
    logic [CNT_W-1:0]     timeouts_seen_reg, timeouts_seen_next;
    logic                 clock_level_reg;
    logic [TIMER_W:0]     timer_plus;
    logic [CNT_W-1:0]     target_n;
    logic [DATA_BITS-1:0] reading_value;

    assign timer_plus = {1'b0, tick_timer_reg} + 1'b1;
    assign target_n   = (cfg.sample_count == '0) ? CNT_W'(1) : cfg.sample_count;

    assign status.timer_ge_timeout = tick_timer_reg >= cfg.timeout_ticks;
    assign status.half_hit         = timer_plus >= (TIMER_W + 1)'(cfg.half_period_ticks);
    assign status.pulse_lt         = pulse_index_reg < PULSE_W'(DATA_BITS);
    assign status.timer_ge_gap     = tick_timer_reg >= TIMER_W'(cfg.gap_ticks);
    assign status.readings_ge_n    = readings_done_reg >= target_n;

    always_comb begin
        reading_value = '0;
        if (cmd.finish_word) begin
            reading_value = shift_word_reg ^ {1'b1, {(DATA_BITS - 1){1'b0}}};
        end
    end

    always_comb begin
        tick_timer_next    = tick_timer_reg;
        pulse_index_next   = pulse_index_reg;
        shift_word_next    = shift_word_reg;
        reading_sum_next   = reading_sum_reg;
        readings_done_next = readings_done_reg;
        timeouts_seen_next = timeouts_seen_reg;
        clock_level_next   = clock_level_reg;

        if (cmd.timer_inc) begin
            tick_timer_next = timer_plus[TIMER_W-1:0];
        end
        if (cmd.timer_clr) begin
            tick_timer_next = '0;
        end
        if (cmd.word_clr) begin
            pulse_index_next = '0;
            shift_word_next  = '0;
        end
        if (cmd.shift_en && status.pulse_lt) begin
            shift_word_next = {shift_word_reg[DATA_BITS-2:0], din};
        end
        if (cmd.pulse_inc) begin
            pulse_index_next = pulse_index_reg + 1'b1;
        end
        if (cmd.timeout_inc && (timeouts_seen_reg != '1)) begin
            timeouts_seen_next = timeouts_seen_reg + 1'b1;
        end
        if (cmd.finish_zero || cmd.finish_word) begin
            reading_sum_next = reading_sum_reg + SUM_W'(reading_value);
            if (readings_done_reg != '1) begin
                readings_done_next = readings_done_reg + 1'b1;
            end
        end
        if (cmd.meas_clr) begin
            reading_sum_next   = '0;
            readings_done_next = '0;
            timeouts_seen_next = '0;
        end
        if (cmd.clk_hi) begin
            clock_level_next = 1'b1;
        end
        if (cmd.clk_lo) begin
            clock_level_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_timer_reg    <= '0;
            pulse_index_reg   <= '0;
            shift_word_reg    <= '0;
            reading_sum_reg   <= '0;
            readings_done_reg <= '0;
            timeouts_seen_reg <= '0;
            clock_level_reg   <= 1'b0;
        end else begin
            tick_timer_reg    <= tick_timer_next;
            pulse_index_reg   <= pulse_index_next;
            shift_word_reg    <= shift_word_next;
            reading_sum_reg   <= reading_sum_next;
            readings_done_reg <= readings_done_next;
            timeouts_seen_reg <= timeouts_seen_next;
            clock_level_reg   <= clock_level_next;
        end
    end

    assign reading_sum   = reading_sum_reg;
    assign readings_done = readings_done_reg;
    assign timeouts_seen = timeouts_seen_reg;

endmodule

// File: src/lcsr_ctrl.sv
module lcsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick,
    input  logic                start_req,
    input  logic                din,
    input  lcsr_pkg::status_t   status,
    output lcsr_pkg::cmd_t      cmd,
    output logic                busy_next
);
    import lcsr_pkg::*;

    phase_t phase_reg, phase_next;

    always_comb begin
        phase_next = phase_reg;
        if (tick) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (start_req) begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (!din) begin
                        phase_next = PH_HIGH;
                    end else if (status.timer_ge_timeout) begin
                        phase_next = PH_GAP;
                    end
                end
                PH_HIGH: begin
                    if (status.half_hit) begin
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (status.half_hit) begin
                        phase_next = status.pulse_lt ? PH_HIGH : PH_GAP;
                    end
                end
                PH_GAP: begin
                    if (status.timer_ge_gap) begin
                        phase_next = status.readings_ge_n ? PH_IDLE : PH_WAIT;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        if (tick) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (start_req) begin
                        cmd.meas_clr  = 1'b1;
                        cmd.timer_clr = 1'b1;
                        cmd.clk_lo    = 1'b1;
                    end
                end
                PH_WAIT: begin
                    if (!din) begin
                        cmd.word_clr  = 1'b1;
                        cmd.timer_clr = 1'b1;
                        cmd.clk_hi    = 1'b1;
                    end else if (status.timer_ge_timeout) begin
                        cmd.timeout_inc = 1'b1;
                        cmd.finish_zero = 1'b1;
                        cmd.timer_clr   = 1'b1;
                        cmd.clk_lo      = 1'b1;
                    end else begin
                        cmd.timer_inc = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (status.half_hit) begin
                        cmd.timer_clr = 1'b1;
                        cmd.clk_lo    = 1'b1;
                    end else begin
                        cmd.timer_inc = 1'b1;
                    end
                end
                PH_LOW: begin
                    if (status.half_hit) begin
                        cmd.timer_clr = 1'b1;
                        cmd.shift_en  = 1'b1;
                        cmd.pulse_inc = 1'b1;
                        if (status.pulse_lt) begin
                            cmd.clk_hi = 1'b1;
                        end else begin
                            cmd.finish_word = 1'b1;
                            cmd.clk_lo      = 1'b1;
                        end
                    end else begin
                        cmd.timer_inc = 1'b1;
                    end
                end
                PH_GAP: begin
                    if (status.timer_ge_gap) begin
                        cmd.timer_clr = 1'b1;
                        cmd.div_start = status.readings_ge_n;
                    end else begin
                        cmd.timer_inc = 1'b1;
                    end
                end
                default: begin
                    cmd.timer_clr = 1'b1;
                    cmd.clk_lo    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    assign busy_next = phase_next != PH_IDLE;

endmodule

// File: src/load_cell_adc_serial_reader_top.sv
// Serial readout master for a two-wire 24-bit load-cell converter. Every input beat is one
// timebase tick and yields exactly one result beat carrying the serial clock level, the busy
// flag and, on the closing tick of a measurement, the truncated mean, the net value and the
// timeout count. Ticks are accepted while the output register is empty or being drained and
// no division is pending. The closing tick starts a restoring divider that retires one
// quotient bit per cycle; the input stalls while the divider runs and until the result beat
// is loaded, which waits while the receiver holds off the previous beat.
// Register writes take effect at once and are meant to happen while no measurement runs.
module load_cell_adc_serial_reader_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_start_req,
    input  logic                                   s_dout,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_sck,
    output logic                                   m_busy_res,
    output logic                                   m_done_res,
    output logic [lcsr_pkg::AVG_W-1:0]             m_average_raw,
    output logic signed [lcsr_pkg::NET_W-1:0]      m_net_value,
    output logic [lcsr_pkg::CNT_W-1:0]             m_timeout_count,
    input  logic                                   cfg_we,
    input  logic [lcsr_pkg::IDX_W-1:0]             cfg_index,
    input  logic [lcsr_pkg::CFG_W-1:0]             cfg_data
);
    import lcsr_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    cmd_t              cmd;
    status_t           status;
    logic              tick;
    logic              busy_next;
    logic              clock_level_next;
    logic [SUM_W-1:0]  reading_sum;
    logic [CNT_W-1:0]  readings_done;
    logic [CNT_W-1:0]  timeouts_seen;
    logic [CNT_W-1:0]  divisor;
    logic              div_busy;
    logic              div_done;
    logic [SUM_W-1:0]  quotient;
    logic [NET_W-1:0]  net;
    logic              pend_reg, pend_next;
    logic              res_load;

    logic              m_valid_reg, m_valid_next;
    logic              sck_reg, sck_next;
    logic              busy_reg, busy_res_next;
    logic              done_reg, done_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [NET_W-1:0]  net_reg, net_next;
    logic [CNT_W-1:0]  tcount_reg, tcount_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_HALF_PERIOD:  cfg_next.half_period_ticks = cfg_data[HALF_W-1:0];
                REG_TIMEOUT:      cfg_next.timeout_ticks     = cfg_data[TIMER_W-1:0];
                REG_GAP:          cfg_next.gap_ticks         = cfg_data[GAP_W-1:0];
                REG_SAMPLE_COUNT: cfg_next.sample_count      = cfg_data[CNT_W-1:0];
                REG_OFFSET:       cfg_next.offset            = cfg_data[OFFSET_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    assign s_ready  = !div_busy && !div_done && !pend_reg && (!m_valid_reg || m_ready);
    assign tick     = s_valid && s_ready;
    assign res_load = (div_done || pend_reg) && (!m_valid_reg || m_ready);

    always_comb begin
        pend_next = pend_reg;
        if (div_done) begin
            pend_next = 1'b1;
        end
        if (res_load) begin
            pend_next = 1'b0;
        end
    end

    lcsr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .start_req (s_start_req),
        .din       (s_dout),
        .status    (status),
        .cmd       (cmd),
        .busy_next (busy_next)
    );

    lcsr_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .din              (s_dout),
        .status           (status),
        .clock_level_next (clock_level_next),
        .reading_sum      (reading_sum),
        .readings_done    (readings_done),
        .timeouts_seen    (timeouts_seen)
    );

    assign divisor = (readings_done == '0) ? CNT_W'(1) : readings_done;

    lcsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (reading_sum),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign net = {{(NET_W - AVG_W){1'b0}}, quotient[AVG_W-1:0]}
               - {{(NET_W - OFFSET_W){cfg_reg.offset[OFFSET_W-1]}}, cfg_reg.offset};

    always_comb begin
        m_valid_next  = m_valid_reg;
        sck_next      = sck_reg;
        busy_res_next = busy_reg;
        done_next     = done_reg;
        avg_next      = avg_reg;
        net_next      = net_reg;
        tcount_next   = tcount_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (tick && !cmd.div_start) begin
            m_valid_next  = 1'b1;
            sck_next      = clock_level_next;
            busy_res_next = busy_next;
            done_next     = 1'b0;
            avg_next      = '0;
            net_next      = '0;
            tcount_next   = '0;
        end else if (res_load) begin
            m_valid_next  = 1'b1;
            sck_next      = 1'b0;
            busy_res_next = 1'b0;
            done_next     = 1'b1;
            avg_next      = quotient[AVG_W-1:0];
            net_next      = net;
            tcount_next   = timeouts_seen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_RESET;
            cfg_reg.timeout_ticks     <= TIMEOUT_RESET;
            cfg_reg.gap_ticks         <= GAP_RESET;
            cfg_reg.sample_count      <= COUNT_RESET;
            cfg_reg.offset            <= OFFSET_RESET;
            m_valid_reg               <= 1'b0;
            pend_reg                  <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        sck_reg    <= sck_next;
        busy_reg   <= busy_res_next;
        done_reg   <= done_next;
        avg_reg    <= avg_next;
        net_reg    <= net_next;
        tcount_reg <= tcount_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_sck           = sck_reg;
    assign m_busy_res      = busy_reg;
    assign m_done_res      = done_reg;
    assign m_average_raw   = avg_reg;
    assign m_net_value     = $signed(net_reg);
    assign m_timeout_count = tcount_reg;

endmodule
